@@ design/de3d_pkg.sv @@
// package: sizes, widths, register indexes and transaction types of the 3d edge detector
`default_nettype none

package de3d_pkg;

    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 4096;

    // coordinate and size widths
    localparam int XW  = $clog2(MAX_X);
    localparam int YW  = $clog2(MAX_Y);
    localparam int ZW  = $clog2(MAX_Z);
    localparam int NXW = $clog2(MAX_X + 1);
    localparam int NYW = $clog2(MAX_Y + 1);
    localparam int NZW = $clog2(MAX_Z + 1);
    localparam int PAW = $clog2(MAX_X * MAX_Y);
    localparam int PLW = $clog2(MAX_X * MAX_Y + 1);
    localparam int TW  = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
    localparam int LW  = $clog2(MAX_X * MAX_Y + MAX_X + 2);
    localparam int CW  = $clog2(MAX_X * MAX_Y * MAX_Z + MAX_X * MAX_Y + MAX_X + 2);

    // configuration register file
    localparam int CFG_IW = 2;
    localparam int CFG_W  = 13;
    localparam int XS_W   = 9;
    localparam int YS_W   = 9;
    localparam int ZS_W   = 13;
    localparam logic [CFG_IW-1:0] REG_X_SIZE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_Y_SIZE = 2'd1;
    localparam logic [CFG_IW-1:0] REG_Z_SIZE = 2'd2;
    localparam logic [XS_W-1:0] X_SIZE_RST = 9'd256;
    localparam logic [YS_W-1:0] Y_SIZE_RST = 9'd256;
    localparam logic [ZS_W-1:0] Z_SIZE_RST = 13'd1;

    // arithmetic widths
    localparam int V_W = 16;
    localparam int D_W = V_W + 1;
    localparam int S_W = V_W + 2;
    localparam int Q_W = 2 * D_W - 1;
    localparam int T_W = Q_W + S_W;
    localparam int A_W = T_W + 2;
    localparam int E_W = 60;

    // cycles the derived sizes need after a register write
    localparam logic [2:0] SETTLE_CYC = 3'd4;

    typedef struct packed {
        logic signed [V_W-1:0] voxel;
        logic                  drain;
    } t_in;

    typedef struct packed {
        logic signed [E_W-1:0] edge_value;
        logic                  last_voxel;
    } t_out;

endpackage

`default_nettype wire

@@ design/differential_edge_3d.sv @@
// top level: 3d second directional derivative edge detector over a raster voxel stream
// throughput: one transaction per clock while ready is high; each result is registered
// out once its neighborhood is complete, i.e. X*Y+X+1 positions after its own voxel
// neighborhood comes from a row buffer (X entries) and a plane buffer (X*Y entries),
// each read when a transaction is accepted and written back when stage 1 advances
// reset and every register write hold ready low while sizes settle
// buffers are not cleared; counters and valid flags clear on reset
`default_nettype none

module differential_edge_3d (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [de3d_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [de3d_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire de3d_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output de3d_pkg::t_out                       o_out_data
);

    localparam int V_W = de3d_pkg::V_W;
    localparam int D_W = de3d_pkg::D_W;
    localparam int S_W = de3d_pkg::S_W;
    localparam int Q_W = de3d_pkg::Q_W;
    localparam int T_W = de3d_pkg::T_W;
    localparam int A_W = de3d_pkg::A_W;
    localparam int E_W = de3d_pkg::E_W;
    localparam int CW  = de3d_pkg::CW;
    localparam int TW  = de3d_pkg::TW;
    localparam int LW  = de3d_pkg::LW;
    localparam int PLW = de3d_pkg::PLW;
    localparam int PAW = de3d_pkg::PAW;
    localparam int NXW = de3d_pkg::NXW;
    localparam int NYW = de3d_pkg::NYW;
    localparam int NZW = de3d_pkg::NZW;
    localparam int XW  = de3d_pkg::XW;
    localparam int YW  = de3d_pkg::YW;
    localparam int ZW  = de3d_pkg::ZW;

    // configuration
    logic [de3d_pkg::XS_W-1:0] r_x_size;
    logic [de3d_pkg::YS_W-1:0] r_y_size;
    logic [de3d_pkg::ZS_W-1:0] r_z_size;
    logic [2:0]                r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= de3d_pkg::X_SIZE_RST;
            r_y_size <= de3d_pkg::Y_SIZE_RST;
            r_z_size <= de3d_pkg::Z_SIZE_RST;
            r_settle <= de3d_pkg::SETTLE_CYC;
        end else begin
            if (i_cfg_we) begin
                r_settle <= de3d_pkg::SETTLE_CYC;
                case (i_cfg_index)
                    de3d_pkg::REG_X_SIZE: r_x_size <= i_cfg_data[de3d_pkg::XS_W-1:0];
                    de3d_pkg::REG_Y_SIZE: r_y_size <= i_cfg_data[de3d_pkg::YS_W-1:0];
                    de3d_pkg::REG_Z_SIZE: r_z_size <= i_cfg_data[de3d_pkg::ZS_W-1:0];
                    default: ;
                endcase
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end
        end
    end

    // derived sizes
    logic [NXW-1:0] r_nx;
    logic [NYW-1:0] r_ny;
    logic [NZW-1:0] r_nz;
    logic [PLW-1:0] r_plane;
    logic [TW-1:0]  r_total;
    logic [LW-1:0]  r_lag;
    logic [CW-1:0]  r_end;

    always_ff @(posedge i_clk) begin
        if (r_x_size == '0)
            r_nx <= NXW'(1);
        else if ({1'b0, r_x_size} > (de3d_pkg::XS_W + 1)'(de3d_pkg::MAX_X))
            r_nx <= NXW'(de3d_pkg::MAX_X);
        else
            r_nx <= NXW'(r_x_size);
        if (r_y_size == '0)
            r_ny <= NYW'(1);
        else if ({1'b0, r_y_size} > (de3d_pkg::YS_W + 1)'(de3d_pkg::MAX_Y))
            r_ny <= NYW'(de3d_pkg::MAX_Y);
        else
            r_ny <= NYW'(r_y_size);
        if (r_z_size == '0)
            r_nz <= NZW'(1);
        else if ({1'b0, r_z_size} > (de3d_pkg::ZS_W + 1)'(de3d_pkg::MAX_Z))
            r_nz <= NZW'(de3d_pkg::MAX_Z);
        else
            r_nz <= NZW'(r_z_size);
        r_plane <= PLW'(r_nx * r_ny);
        r_total <= TW'(r_plane * r_nz);
        r_lag   <= LW'(r_plane) + LW'(r_nx) + LW'(1);
        r_end   <= CW'(r_total) + CW'(r_lag);
    end

    // stream position bookkeeping
    logic [CW-1:0]  r_p;
    logic [XW-1:0]  r_ix;
    logic [PAW-1:0] r_pa;
    logic [XW-1:0]  r_ox;
    logic [YW-1:0]  r_oy;
    logic [ZW-1:0]  r_oz;

    logic adv;
    logic skid_vld;
    logic accept;
    logic in_volume;
    logic step;
    logic emit;
    logic wrap;
    logic last;
    logic interior;
    logic [CW:0] p_inc;

    assign adv        = !skid_vld;
    assign o_in_ready = adv && (r_settle == 3'd0);
    assign accept     = i_in_valid && o_in_ready;
    assign in_volume  = CW'(r_total) > r_p;
    assign step       = accept && !(in_volume && i_in_data.drain);
    assign p_inc      = {1'b0, r_p} + (CW + 1)'(1);
    assign emit       = (r_p >= CW'(r_lag)) && (r_p < r_end);
    assign wrap       = p_inc >= {1'b0, r_end};
    assign last       = emit && (p_inc == {1'b0, r_end});
    assign interior   = (r_ox != '0) && ((NXW'(r_ox) + NXW'(1)) < r_nx)
                     && (r_oy != '0) && ((NYW'(r_oy) + NYW'(1)) < r_ny)
                     && (r_oz != '0) && ((NZW'(r_oz) + NZW'(1)) < r_nz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_ix <= '0;
            r_pa <= '0;
            r_ox <= '0;
            r_oy <= '0;
            r_oz <= '0;
        end else if (step) begin
            if (wrap) begin
                r_p  <= '0;
                r_ix <= '0;
                r_pa <= '0;
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= '0;
            end else begin
                r_p <= p_inc[CW-1:0];
                if ((NXW'(r_ix) + NXW'(1)) >= r_nx)
                    r_ix <= '0;
                else
                    r_ix <= r_ix + XW'(1);
                if ((PLW'(r_pa) + PLW'(1)) >= r_plane)
                    r_pa <= '0;
                else
                    r_pa <= r_pa + PAW'(1);
                if (emit) begin
                    if ((NXW'(r_ox) + NXW'(1)) >= r_nx) begin
                        r_ox <= '0;
                        if ((NYW'(r_oy) + NYW'(1)) >= r_ny) begin
                            r_oy <= '0;
                            if ((NZW'(r_oz) + NZW'(1)) >= r_nz)
                                r_oz <= '0;
                            else
                                r_oz <= r_oz + ZW'(1);
                        end else begin
                            r_oy <= r_oy + YW'(1);
                        end
                    end else begin
                        r_ox <= r_ox + XW'(1);
                    end
                end
            end
        end
    end

    // stage 1: buffer read data returns
    logic                  r_s1_vld;
    logic                  r_s1_emit;
    logic                  r_s1_int;
    logic                  r_s1_last;
    logic signed [V_W-1:0] r_s1_voxel;
    logic [XW-1:0]         r_s1_ix;
    logic [PAW-1:0]        r_s1_pa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_emit  <= emit;
            r_s1_int   <= interior;
            r_s1_last  <= last;
            r_s1_voxel <= i_in_data.voxel;
            r_s1_ix    <= r_ix;
            r_s1_pa    <= r_pa;
        end
    end

    // row buffer holds {v(p-X), v(p-2X)}, plane buffer holds {col(p-P), col(p-2P)}
    logic [2*V_W-1:0] r_row_mem [0:de3d_pkg::MAX_X-1];
    logic [2*V_W-1:0] r_row_rd;
    logic [6*V_W-1:0] r_pln_mem [0:de3d_pkg::MAX_X*de3d_pkg::MAX_Y-1];
    logic [6*V_W-1:0] r_pln_rd;
    logic             s1_wr;
    logic [3*V_W-1:0] col_now;

    assign s1_wr   = r_s1_vld && adv;
    assign col_now = {r_s1_voxel, r_row_rd};

    always_ff @(posedge i_clk) begin
        if (step)
            r_row_rd <= r_row_mem[r_ix];
        if (s1_wr)
            r_row_mem[r_s1_ix] <= {r_s1_voxel, r_row_rd[2*V_W-1:V_W]};
    end

    always_ff @(posedge i_clk) begin
        if (step)
            r_pln_rd <= r_pln_mem[r_pa];
        if (s1_wr)
            r_pln_mem[r_s1_pa] <= {col_now, r_pln_rd[6*V_W-1:3*V_W]};
    end

    // stage 2: 3x9 window, column 0 newest; row k = 3*plane_delay + row_delay
    logic signed [V_W-1:0] r_win [0:2][0:8];
    logic [9*V_W-1:0]      col9;
    logic                  r_s2_vld;
    logic                  r_s2_int;
    logic                  r_s2_last;

    assign col9 = {col_now, r_pln_rd};

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            for (int k = 0; k < 9; k++) begin
                r_win[2][k] <= r_win[1][k];
                r_win[1][k] <= r_win[0][k];
                r_win[0][k] <= col9[(9-k)*V_W-1 -: V_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_int  <= r_s1_int;
            r_s2_last <= r_s1_last;
        end
    end

    // stage 3: differences
    logic signed [D_W-1:0] r_dx, r_dy, r_dz;
    logic signed [S_W-1:0] r_sxx, r_syy, r_szz, r_mxy, r_mxz, r_myz;
    logic                  r_s3_vld, r_s3_int, r_s3_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx  <= D_W'(r_win[0][4]) - D_W'(r_win[2][4]);
            r_dy  <= D_W'(r_win[1][3]) - D_W'(r_win[1][5]);
            r_dz  <= D_W'(r_win[1][1]) - D_W'(r_win[1][7]);
            r_sxx <= S_W'(r_win[0][4]) + S_W'(r_win[2][4]) - (S_W'(r_win[1][4]) <<< 1);
            r_syy <= S_W'(r_win[1][3]) + S_W'(r_win[1][5]) - (S_W'(r_win[1][4]) <<< 1);
            r_szz <= S_W'(r_win[1][1]) + S_W'(r_win[1][7]) - (S_W'(r_win[1][4]) <<< 1);
            r_mxy <= S_W'(r_win[0][3]) - S_W'(r_win[2][3])
                   - S_W'(r_win[0][5]) + S_W'(r_win[2][5]);
            r_mxz <= S_W'(r_win[0][1]) - S_W'(r_win[2][1])
                   - S_W'(r_win[0][7]) + S_W'(r_win[2][7]);
            r_myz <= S_W'(r_win[1][0]) - S_W'(r_win[1][2])
                   - S_W'(r_win[1][6]) + S_W'(r_win[1][8]);
            r_s3_int  <= r_s2_int;
            r_s3_last <= r_s2_last;
        end
    end

    // stage 4: gradient products
    logic signed [Q_W-1:0] r_qxx, r_qyy, r_qzz, r_qxy, r_qxz, r_qyz;
    logic signed [S_W-1:0] r_s4_sxx, r_s4_syy, r_s4_szz, r_s4_mxy, r_s4_mxz, r_s4_myz;
    logic                  r_s4_vld, r_s4_int, r_s4_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qxx    <= Q_W'(r_dx) * Q_W'(r_dx);
            r_qyy    <= Q_W'(r_dy) * Q_W'(r_dy);
            r_qzz    <= Q_W'(r_dz) * Q_W'(r_dz);
            r_qxy    <= Q_W'(r_dx) * Q_W'(r_dy);
            r_qxz    <= Q_W'(r_dx) * Q_W'(r_dz);
            r_qyz    <= Q_W'(r_dy) * Q_W'(r_dz);
            r_s4_sxx <= r_sxx;
            r_s4_syy <= r_syy;
            r_s4_szz <= r_szz;
            r_s4_mxy <= r_mxy;
            r_s4_mxz <= r_mxz;
            r_s4_myz <= r_myz;
            r_s4_int  <= r_s3_int;
            r_s4_last <= r_s3_last;
        end
    end

    // stage 5: hessian terms
    logic signed [T_W-1:0] r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;
    logic                  r_s5_vld, r_s5_int, r_s5_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t1 <= T_W'(r_qxx) * T_W'(r_s4_sxx);
            r_t2 <= T_W'(r_qyy) * T_W'(r_s4_syy);
            r_t3 <= T_W'(r_qzz) * T_W'(r_s4_szz);
            r_t4 <= T_W'(r_qxy) * T_W'(r_s4_mxy);
            r_t5 <= T_W'(r_qxz) * T_W'(r_s4_mxz);
            r_t6 <= T_W'(r_qyz) * T_W'(r_s4_myz);
            r_s5_int  <= r_s4_int;
            r_s5_last <= r_s4_last;
        end
    end

    // stage 6: partial sums
    logic signed [A_W-1:0] r_sum_d, r_sum_m;
    logic                  r_s6_vld, r_s6_int, r_s6_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum_d   <= A_W'(r_t1) + A_W'(r_t2) + A_W'(r_t3);
            r_sum_m   <= A_W'(r_t4) + A_W'(r_t5) + A_W'(r_t6);
            r_s6_int  <= r_s5_int;
            r_s6_last <= r_s5_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    // final sum, output register and skid
    de3d_pkg::t_out res;
    de3d_pkg::t_out r_out;
    de3d_pkg::t_out r_skid;
    logic           r_out_vld;
    logic           r_skid_vld;
    logic           out_free;

    always_comb begin
        res.last_voxel = r_s6_last;
        if (r_s6_int)
            res.edge_value = E_W'(r_sum_d) + (E_W'(r_sum_m) <<< 1);
        else
            res.edge_value = '0;
    end

    assign skid_vld = r_skid_vld;
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld || r_s6_vld)
                r_out_vld <= 1'b1;
            else if (i_out_ready)
                r_out_vld <= 1'b0;
            if (r_skid_vld) begin
                if (out_free)
                    r_skid_vld <= 1'b0;
            end else if (r_s6_vld && !out_free) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free)
                r_out <= r_skid;
        end else if (r_s6_vld) begin
            if (out_free)
                r_out <= res;
            else
                r_skid <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
